// File: design/rx_frame_admission_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the receive frame admission filter
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef RX_FRAME_ADMISSION_FILTER_ASSERT_SVH
`define RX_FRAME_ADMISSION_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a full property on the rising clock edge, off while reset is held.
`define RXFAF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rxfaf assertion failed: %m");

// Check that a condition implies another in the same cycle.
`define RXFAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rxfaf implication failed: %m");

`else

`define RXFAF_ASSERT(lbl, clk, rst_n, prop)

`define RXFAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/rxfaf_pkg.sv
// ----------------------------------------------------------------------------
// rxfaf_pkg
// Types and constants shared by the receive frame admission filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rxfaf_pkg;

	localparam int DEF_FILTER_ENTRIES = 16;
	localparam int MAX_FRAME          = 1600;

	localparam int ADDR_W   = 48;
	localparam int PTR_W    = 16;
	localparam int DLV_W    = 11;
	localparam int CNT_W    = 5;
	localparam int IDX_IN_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] BCAST_OCTET = 8'hFF;

	typedef enum logic [2:0] {
		ACT_IDLE     = 3'd0,
		ACT_WRITTEN  = 3'd1,
		ACT_SKIPPED  = 3'd2,
		ACT_DROPPED  = 3'd3,
		ACT_ACCEPTED = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUNNING      = 2'd0,
		REG_PROMISCUOUS  = 2'd1,
		REG_FILTER_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		FUNC_WRITE_ENTRY = 1'b0,
		FUNC_EXAMINE     = 1'b1
	} func_t;

	typedef struct packed {
		logic                func;
		logic [IDX_IN_W-1:0] entry_index;
		logic [ADDR_W-1:0]   entry_address;
		logic [PTR_W-1:0]    received_size;
		logic [PTR_W-1:0]    read_pointer;
		logic [PTR_W-1:0]    header_length;
		logic [ADDR_W-1:0]   destination_address;
	} in_word_t;

	typedef struct packed {
		action_t            action;
		logic [PTR_W-1:0]   new_read_pointer;
		logic [PTR_W-1:0]   payload_pointer;
		logic [DLV_W-1:0]   deliver_length;
		logic               release_res;
		logic               check_link;
	} out_word_t;

	// Table write request from the first stage to the match unit.
	typedef struct packed {
		logic                we;
		logic [IDX_IN_W-1:0] idx;
		logic [ADDR_W-1:0]   addr;
	} tbl_wr_t;

endpackage

`default_nettype wire

// File: design/rxfaf_match.sv
// ----------------------------------------------------------------------------
// rxfaf_match
// Multicast address table with one registered comparator per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rxfaf_match
	import rxfaf_pkg::*;
#(
	parameter int FILTER_ENTRIES = DEF_FILTER_ENTRIES
) (
	input  wire logic                      clk,
	input  wire tbl_wr_t                   wr,
	input  wire logic                      cmp_en,
	input  wire logic [ADDR_W-1:0]         dst,
	input  wire logic [CNT_W-1:0]          count,
	output logic      [FILTER_ENTRIES-1:0] hit_s3
);

	logic [ADDR_W-1:0] entry_q [FILTER_ENTRIES];

	for (genvar i = 0; i < FILTER_ENTRIES; i++) begin : g_entry
		// Entries past the last index an item can name are never written.
		always_ff @(posedge clk) begin
			if (wr.we && (32'(wr.idx) == i)) begin
				entry_q[i] <= wr.addr;
			end
		end

		always_ff @(posedge clk) begin
			if (cmp_en) begin
				hit_s3[i] <= (i < 32'(count)) && (entry_q[i] == dst);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rx_frame_admission_filter.sv
// ----------------------------------------------------------------------------
// rx_frame_admission_filter
// Receive ring frame admission with an exact multicast address filter.
// ----------------------------------------------------------------------------
// Each word on the item channel either loads one multicast table slot or
// presents the frame at the head of a receive ring. For a frame the block
// checks the length header, applies the multicast filter and returns one
// result word: the action, the new ring read pointer, the payload pointer,
// the length handed upward (clamped to MAX_FRAME) and the release flag.
// Throughput is one word per clock when the result channel does not stall.
// The four stages are: input register, header decode and destination
// masking, the per-entry address compare, and the final decision into the
// output register. Each stage stalls only when it holds a word and the
// stage after it cannot take one, so bubbles close up and a held result
// does not block items upstream of an empty stage. A table write lands as
// the word leaves the first stage, so any frame behind it sees the new
// entry. Configuration must be written only while the block is idle; the
// block itself does not enforce this. Table slots come out of reset
// undefined; frames must not match against slots inside filter_count that
// were never written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rx_frame_admission_filter_assert.svh"

module rx_frame_admission_filter
	import rxfaf_pkg::*;
#(
	parameter int FILTER_ENTRIES = DEF_FILTER_ENTRIES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item channel
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire in_word_t             item,
	// result channel
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output out_word_t                 result,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		CLS_WRITE,
		CLS_OFF,
		CLS_EMPTY,
		CLS_SKIP,
		CLS_FRAME
	} cls_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic             running_q;
	logic             promisc_q;
	logic [CNT_W-1:0] fcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			promisc_q <= 1'b0;
			fcount_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RUNNING:      running_q <= cfg_data[0];
				REG_PROMISCUOUS:  promisc_q <= cfg_data[0];
				REG_FILTER_COUNT: fcount_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage handshake: a stage loads when empty or when it drains
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4 = !valid_s4 || !result_stall;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign item_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= item_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the input word
	// ------------------------------------------------------------------
	in_word_t item_s1;

	always_ff @(posedge clk) begin
		if (adv1 && item_valid) begin
			item_s1 <= item;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 -> 2: classify, work out pointers, mask short destinations
	// ------------------------------------------------------------------
	logic              hdr_short;
	logic [PTR_W-1:0]  dlen;
	logic [PTR_W-1:0]  pay;
	logic [PTR_W-1:0]  newptr;
	logic [5:0]        keep;
	logic [ADDR_W-1:0] dst_masked;
	logic [7:0]        first_octet;
	logic              needs_filter;
	cls_t              cls_d;

	always_comb begin
		hdr_short = item_s1.header_length < PTR_W'(2);
		dlen      = item_s1.header_length - PTR_W'(2);
		pay       = item_s1.read_pointer + PTR_W'(2);
		// Short headers skip past the header too; otherwise the header counts itself.
		newptr    = item_s1.read_pointer + item_s1.header_length
		            + {{(PTR_W-2){1'b0}}, hdr_short, 1'b0};

		// Zero every destination byte that lies past the payload.
		for (int k = 0; k < 6; k++) begin
			keep[k] = dlen > PTR_W'(k);
			dst_masked[ADDR_W-1-8*k -: 8] =
				keep[k] ? item_s1.destination_address[ADDR_W-1-8*k -: 8] : 8'h00;
		end

		// Multicast, but only the first octet is tested for broadcast.
		first_octet  = dst_masked[ADDR_W-1 -: 8];
		needs_filter = !promisc_q && first_octet[0] && (first_octet != BCAST_OCTET);

		priority if (item_s1.func == FUNC_WRITE_ENTRY) begin
			cls_d = CLS_WRITE;
		end else if (!running_q) begin
			cls_d = CLS_OFF;
		end else if (item_s1.received_size == '0) begin
			cls_d = CLS_EMPTY;
		end else if (hdr_short) begin
			cls_d = CLS_SKIP;
		end else begin
			cls_d = CLS_FRAME;
		end
	end

	cls_t              cls_s2;
	logic [PTR_W-1:0]  rptr_s2;
	logic [PTR_W-1:0]  newptr_s2;
	logic [PTR_W-1:0]  pay_s2;
	logic [PTR_W-1:0]  dlen_s2;
	logic [ADDR_W-1:0] dst_s2;
	logic              filt_s2;

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			cls_s2    <= cls_d;
			rptr_s2   <= item_s1.read_pointer;
			newptr_s2 <= newptr;
			pay_s2    <= pay;
			dlen_s2   <= dlen;
			dst_s2    <= dst_masked;
			filt_s2   <= needs_filter;
		end
	end

	// Table write lands as the entry word leaves stage 1.
	tbl_wr_t tbl_wr;

	always_comb begin
		tbl_wr.we   = adv2 && valid_s1 && (item_s1.func == FUNC_WRITE_ENTRY);
		tbl_wr.idx  = item_s1.entry_index;
		tbl_wr.addr = item_s1.entry_address;
	end

	// ------------------------------------------------------------------
	// Stage 2 -> 3: per-entry compare, clamp the delivered length
	// ------------------------------------------------------------------
	logic [FILTER_ENTRIES-1:0] hit_s3;

	rxfaf_match #(
		.FILTER_ENTRIES(FILTER_ENTRIES)
	) u_match (
		.clk    (clk),
		.wr     (tbl_wr),
		.cmp_en (adv3 && valid_s2),
		.dst    (dst_s2),
		.count  (fcount_q),
		.hit_s3 (hit_s3)
	);

	logic [PTR_W-1:0] dlv_clamp;

	assign dlv_clamp = (dlen_s2 > PTR_W'(MAX_FRAME)) ? PTR_W'(MAX_FRAME) : dlen_s2;

	cls_t             cls_s3;
	logic [PTR_W-1:0] newptr_s3;
	logic [PTR_W-1:0] pay_s3;
	logic [DLV_W-1:0] dlv_s3;
	logic             filt_s3;

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			cls_s3    <= cls_s2;
			// Nothing pending reports the read pointer unchanged.
			newptr_s3 <= (cls_s2 == CLS_EMPTY) ? rptr_s2 : newptr_s2;
			pay_s3    <= pay_s2;
			dlv_s3    <= dlv_clamp[DLV_W-1:0];
			filt_s3   <= filt_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 -> 4: decide and build the result word
	// ------------------------------------------------------------------
	out_word_t res_d;

	always_comb begin
		res_d = '{
			action:           ACT_IDLE,
			new_read_pointer: '0,
			payload_pointer:  '0,
			deliver_length:   '0,
			release_res:      1'b0,
			check_link:       1'b0
		};
		unique case (cls_s3)
			CLS_WRITE: begin
				res_d.action = ACT_WRITTEN;
			end
			CLS_OFF: ;
			CLS_EMPTY: begin
				res_d.new_read_pointer = newptr_s3;
				res_d.check_link       = 1'b1;
			end
			CLS_SKIP: begin
				res_d.action           = ACT_SKIPPED;
				res_d.new_read_pointer = newptr_s3;
				res_d.payload_pointer  = pay_s3;
				res_d.release_res      = 1'b1;
			end
			CLS_FRAME: begin
				res_d.new_read_pointer = newptr_s3;
				res_d.payload_pointer  = pay_s3;
				res_d.release_res      = 1'b1;
				// Drop an unwanted multicast; accept everything else.
				if (filt_s3 && !(|hit_s3)) begin
					res_d.action = ACT_DROPPED;
				end else begin
					res_d.action         = ACT_ACCEPTED;
					res_d.deliver_length = dlv_s3;
				end
			end
			default: ;
		endcase
	end

	out_word_t result_s4;

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			result_s4 <= res_d;
		end
	end

	assign result_valid = valid_s4;
	assign result       = result_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`RXFAF_ASSERT_IMPL(a_release_matches_action, clk, arst_n, result_valid,
		result.release_res == ((result.action == ACT_SKIPPED) ||
		(result.action == ACT_DROPPED) || (result.action == ACT_ACCEPTED)))
	`RXFAF_ASSERT_IMPL(a_length_only_on_accept, clk, arst_n,
		result_valid && (result.deliver_length != '0), result.action == ACT_ACCEPTED)
	`RXFAF_ASSERT_IMPL(a_link_probe_idle, clk, arst_n, result_valid && result.check_link,
		(result.action == ACT_IDLE) && (result.payload_pointer == '0))
	`RXFAF_ASSERT(a_stall_only_when_full, clk, arst_n,
		item_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_stall))

endmodule

`default_nettype wire

// File: bench/rx_frame_admission_filter_tb.sv
// ----------------------------------------------------------------------------
// rx_frame_admission_filter_tb
// Self-checking bench for the receive frame admission filter.
// ----------------------------------------------------------------------------
// An in-bench predictor tracks the multicast table and the three registers.
// It works out the result word for every item word the block accepts. A
// monitor compares each accepted result word, field by field, with the oldest
// prediction. Directed tests load the table and walk the length and filter
// corner cases. Random phases then sweep the register settings. Both channels
// idle at random, and one phase runs with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_frame_admission_filter_tb;
	import rxfaf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_WORDS    = 135;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	in_word_t             item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	out_word_t            result;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_RUNNING;
	logic [CNT_W-1:0]     cfg_data     = '0;

	// Shadow copy of the block state used for prediction.
	logic [ADDR_W-1:0] addr_table [DEF_FILTER_ENTRIES];
	logic              run_on;
	logic              promisc_on;
	logic [CNT_W-1:0]  count_val;

	out_word_t pending_results [$];
	int        mismatch_count = 0;
	bit        steady = 1'b0;

	rx_frame_admission_filter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Random idling on either side, off while the steady flag is up.
	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 9);
	endfunction

	function automatic logic [ADDR_W-1:0] rand48();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// Predict the result word for one accepted item word; a table write
	// updates the shadow table so later frames see it.
	function automatic out_word_t admit_frame(in_word_t w);
		out_word_t         r;
		logic [PTR_W-1:0]  pay;
		logic [PTR_W-1:0]  dlen;
		logic [ADDR_W-1:0] dst;
		logic [7:0]        first;
		int                n;
		bit                hit;
		r = '0;
		r.action = ACT_IDLE;
		if (w.func == FUNC_WRITE_ENTRY) begin
			addr_table[w.entry_index] = w.entry_address;
			r.action = ACT_WRITTEN;
			return r;
		end
		if (!run_on)
			return r;
		if (w.received_size == '0) begin
			r.new_read_pointer = w.read_pointer;
			r.check_link = 1'b1;
			return r;
		end
		pay = w.read_pointer + PTR_W'(2);
		r.payload_pointer = pay;
		r.release_res = 1'b1;
		if (w.header_length < PTR_W'(2)) begin
			r.action = ACT_SKIPPED;
			r.new_read_pointer = pay + w.header_length;
			return r;
		end
		dlen = w.header_length - PTR_W'(2);
		r.new_read_pointer = pay + dlen;
		// Destination bytes past the payload read as zero.
		dst = w.destination_address;
		if (dlen < PTR_W'(6))
			dst = dst & ~({ADDR_W{1'b1}} >> (8 * dlen));
		first = dst[ADDR_W-1 -: 8];
		n = (int'(count_val) > DEF_FILTER_ENTRIES) ? DEF_FILTER_ENTRIES : int'(count_val);
		if (!promisc_on && first[0] && first != BCAST_OCTET) begin
			hit = 1'b0;
			for (int i = 0; i < n; i++)
				if (addr_table[i] == dst)
					hit = 1'b1;
			if (!hit) begin
				r.action = ACT_DROPPED;
				return r;
			end
		end
		r.action = ACT_ACCEPTED;
		if (dlen > PTR_W'(MAX_FRAME))
			r.deliver_length = DLV_W'(MAX_FRAME);
		else
			r.deliver_length = dlen[DLV_W-1:0];
		return r;
	endfunction

	// Offer one item word, idle at random first, and hold it until taken.
	task automatic send_word(in_word_t w);
		@(negedge clk);
		while (take_break()) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (item_stall);
		pending_results.push_back(admit_frame(w));
	endtask

	// Drop valid and hold off until every predicted result word is back.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Write one register with the block idle, and track it in the shadow.
	task automatic write_reg(cfg_reg_t r, logic [CNT_W-1:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_RUNNING:      run_on = v[0];
			REG_PROMISCUOUS:  promisc_on = v[0];
			REG_FILTER_COUNT: count_val = v;
			default: ;
		endcase
	endtask

	task automatic set_mode(logic run, logic promisc, logic [CNT_W-1:0] cnt);
		write_reg(REG_RUNNING, CNT_W'(run));
		write_reg(REG_PROMISCUOUS, CNT_W'(promisc));
		write_reg(REG_FILTER_COUNT, cnt);
	endtask

	function automatic in_word_t frame_word(logic [PTR_W-1:0] size, logic [PTR_W-1:0] rptr,
			logic [PTR_W-1:0] hlen, logic [ADDR_W-1:0] dst);
		in_word_t w;
		w.func = FUNC_EXAMINE;
		w.entry_index = IDX_IN_W'($urandom());
		w.entry_address = rand48();
		w.received_size = size;
		w.read_pointer = rptr;
		w.header_length = hlen;
		w.destination_address = dst;
		return w;
	endfunction

	function automatic in_word_t entry_word(logic [IDX_IN_W-1:0] idx, logic [ADDR_W-1:0] addr);
		in_word_t w;
		w = frame_word(PTR_W'($urandom()), PTR_W'($urandom()), PTR_W'($urandom()), rand48());
		w.func = FUNC_WRITE_ENTRY;
		w.entry_index = idx;
		w.entry_address = addr;
		return w;
	endfunction

	// Random word: mostly frames with a mix of destinations and lengths,
	// with some table rewrites along the way.
	function automatic in_word_t random_word();
		logic [ADDR_W-1:0] dst;
		logic [PTR_W-1:0]  hlen;
		logic [PTR_W-1:0]  size;
		logic [PTR_W-1:0]  rptr;
		if ($urandom_range(0, 99) < 15)
			return entry_word(IDX_IN_W'($urandom()), rand48());
		dst = rand48();
		case ($urandom_range(0, 4))
			0: dst = addr_table[$urandom_range(0, DEF_FILTER_ENTRIES - 1)];
			1: dst[40] = 1'b1;
			2: dst[ADDR_W-1 -: 8] = BCAST_OCTET;
			3: dst[40] = 1'b0;
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0:       hlen = PTR_W'($urandom_range(0, 1));
			1, 2:    hlen = PTR_W'($urandom_range(2, 8));
			7:       hlen = PTR_W'($urandom_range(MAX_FRAME - 2, MAX_FRAME + 6));
			8:       hlen = PTR_W'($urandom());
			9:       hlen = PTR_W'($urandom_range(60000, 65535));
			default: hlen = PTR_W'($urandom_range(9, 1700));
		endcase
		size = ($urandom_range(0, 11) == 0) ? '0 : PTR_W'($urandom_range(1, 65535));
		rptr = ($urandom_range(0, 9) == 0) ? PTR_W'($urandom_range(65520, 65535))
			: PTR_W'($urandom());
		return frame_word(size, rptr, hlen, dst);
	endfunction

	// Fill every slot so no frame ever compares against an unwritten one.
	task automatic test_table_load();
		logic [ADDR_W-1:0] a;
		send_word(entry_word(4'd0, 48'h01_00_00_00_00_00));
		send_word(entry_word(4'd1, 48'h01_00_5E_00_00_00));
		for (int i = 2; i < DEF_FILTER_ENTRIES; i++) begin
			a = rand48();
			a[ADDR_W-1 -: 8] = {1'b0, a[46:41], 1'b1};
			send_word(entry_word(IDX_IN_W'(i), a));
		end
	endtask

	// Frames do nothing while the interface is stopped.
	task automatic test_not_running();
		send_word(frame_word('0, PTR_W'($urandom()), 16'd64, rand48()));
		send_word(frame_word(16'd100, PTR_W'($urandom()), 16'd64, rand48()));
	endtask

	task automatic test_frame_decisions();
		logic [ADDR_W-1:0] mc;
		set_mode(1'b1, 1'b0, CNT_W'(DEF_FILTER_ENTRIES));
		mc = rand48();
		mc[40] = 1'b1;
		// nothing pending, then short headers
		send_word(frame_word('0, 16'h1234, 16'd64, rand48()));
		send_word(frame_word(16'd10, 16'hFFFF, 16'd0, mc));
		send_word(frame_word(16'd10, 16'h0100, 16'd1, mc));
		// short payloads mask the destination
		send_word(frame_word(16'd10, 16'h0200, 16'd2, mc));
		send_word(frame_word(16'd10, 16'h0300, 16'd3, 48'h01_77_66_55_44_33));
		send_word(frame_word(16'd10, 16'h0400, 16'd3, 48'h03_77_66_55_44_33));
		send_word(frame_word(16'd10, 16'h0500, 16'd5, 48'h01_00_5E_AB_CD_EF));
		// full destinations: hit, miss, broadcast, unicast
		send_word(frame_word(16'd80, 16'h0600, 16'd64, addr_table[DEF_FILTER_ENTRIES - 1]));
		send_word(frame_word(16'd80, 16'h0700, 16'd64, {8'h0B, 40'(rand48())}));
		send_word(frame_word(16'd80, 16'h0800, 16'd64, {BCAST_OCTET, 40'(rand48())}));
		send_word(frame_word(16'd80, 16'h0900, 16'd64, 48'hFFFF_FFFF_FFFF));
		send_word(frame_word(16'd80, 16'h0A00, 16'd64, 48'h00_11_22_33_44_55));
	endtask

	task automatic test_length_clamp();
		send_word(frame_word(16'hFFFF, 16'h1000, PTR_W'(MAX_FRAME + 2), rand48()));
		send_word(frame_word(16'hFFFF, 16'h2000, PTR_W'(MAX_FRAME + 3), rand48()));
		send_word(frame_word(16'h0001, 16'hFFF0, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
	endtask

	task automatic random_phase(logic run, logic promisc, logic [CNT_W-1:0] cnt, bit calm);
		set_mode(run, promisc, cnt);
		steady = calm;
		repeat (PHASE_WORDS) send_word(random_word());
		steady = 1'b0;
	endtask

	task automatic test_random_phases();
		random_phase(1'b1, 1'b0, CNT_W'(DEF_FILTER_ENTRIES), 1'b0);
		random_phase(1'b1, 1'b0, '0, 1'b0);
		random_phase(1'b1, 1'b1, CNT_W'(5), 1'b1);
		random_phase(1'b1, 1'b0, {CNT_W{1'b1}}, 1'b0);
		random_phase(1'b0, 1'b0, CNT_W'(3), 1'b0);
		random_phase(1'b1, 1'b0, CNT_W'(1), 1'b0);
	endtask

	// Stall the result channel at random.
	always @(negedge clk)
		result_stall <= take_break();

	task automatic check_result(out_word_t exp_w, out_word_t got);
		if (got.action !== exp_w.action) begin
			$error("action: expected %0d, actual %0d", exp_w.action, got.action);
			mismatch_count++;
		end
		if (got.new_read_pointer !== exp_w.new_read_pointer) begin
			$error("new_read_pointer: expected %0h, actual %0h",
				exp_w.new_read_pointer, got.new_read_pointer);
			mismatch_count++;
		end
		if (got.payload_pointer !== exp_w.payload_pointer) begin
			$error("payload_pointer: expected %0h, actual %0h",
				exp_w.payload_pointer, got.payload_pointer);
			mismatch_count++;
		end
		if (got.deliver_length !== exp_w.deliver_length) begin
			$error("deliver_length: expected %0d, actual %0d",
				exp_w.deliver_length, got.deliver_length);
			mismatch_count++;
		end
		if (got.release_res !== exp_w.release_res) begin
			$error("release_res: expected %0b, actual %0b", exp_w.release_res, got.release_res);
			mismatch_count++;
		end
		if (got.check_link !== exp_w.check_link) begin
			$error("check_link: expected %0b, actual %0b", exp_w.check_link, got.check_link);
			mismatch_count++;
		end
	endtask

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with no prediction waiting");
				mismatch_count++;
			end else begin
				check_result(pending_results.pop_front(), result);
			end
		end
	end

	// End the run if neither channel moves a word for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL rx_frame_admission_filter");
		$finish;
	end

	initial begin
		for (int i = 0; i < DEF_FILTER_ENTRIES; i++)
			addr_table[i] = '0;
		run_on = 1'b0;
		promisc_on = 1'b0;
		count_val = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_table_load();
		test_not_running();
		test_frame_decisions();
		test_length_clamp();
		test_random_phases();

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("PASS rx_frame_admission_filter");
		else
			$display("FAIL rx_frame_admission_filter");
		$finish;
	end

endmodule

`default_nettype wire
